/* rtl/vslp_pkg.sv */
package vslp_pkg;

    localparam int CMD_W      = 2;
    localparam int COORD_W    = 16;
    localparam int CLASS_W    = 4;
    localparam int LEVEL_W    = 4;
    localparam int BRICK_W    = 7;
    localparam int CHANGED_W  = 22;
    localparam int VALUE_W    = 32;
    localparam int DIM_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 56;

    // signed offset, square and sum widths of the distance test
    localparam int D_W   = 18;
    localparam int SQ_W  = 32;
    localparam int SUM_W = 34;

    // compare width for brick coordinates against grid sizes
    localparam int QC_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_DIM_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_Z = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PAINT = 2'd0,
        CMD_GEN   = 2'd1,
        CMD_COUNT = 2'd2,
        CMD_EDIT  = 2'd3
    } cmd_code_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_BOX,
        ST_START,
        ST_ROW_SQ,
        ST_ROW_SUM,
        ST_SCAN,
        ST_DRAIN,
        ST_BUMP_RD,
        ST_BUMP_WR,
        ST_FINISH,
        ST_GEN_RD,
        ST_GEN_WAIT,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic latch;
        logic box;
        logic start;
        logic row_sq;
        logic row_sum;
        logic scan;
        logic bump_start;
        logic bump_rd;
        logic bump_wr;
        logic bump_adv;
        logic finish;
        logic gen_rd;
        logic gen_cap;
        logic load_out;
        logic clear;
    } dp_cmd_t;

    typedef struct packed {
        cmd_code_t code;
        logic      bad_class;
        logic      vol_ok;
        logic      box_empty;
        logic      x_last;
        logic      row_last;
        logic      bump_hit;
        logic      bump_end;
        logic      clr_last;
        logic      cfg_clear;
    } dp_status_t;

endpackage

/* rtl/vslp_ram.sv */
module vslp_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/vslp_ctrl.sv */
module vslp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  vslp_pkg::dp_status_t sts,
    output vslp_pkg::dp_cmd_t    ctl
);
    import vslp_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctl.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (sts.code)
                    CMD_PAINT:
                    begin
                        if (sts.bad_class || !sts.vol_ok)
                        begin
                            state_next = ST_RESULT;
                        end
                        else
                        begin
                            state_next = ST_BOX;
                        end
                    end
                    CMD_GEN:   state_next = ST_GEN_RD;
                    CMD_COUNT: state_next = ST_RESULT;
                    CMD_EDIT:  state_next = ST_RESULT;
                endcase
            end
            ST_BOX:     state_next = ST_START;
            ST_START:
            begin
                if (sts.box_empty)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_ROW_SQ;
                end
            end
            ST_ROW_SQ:  state_next = ST_ROW_SUM;
            ST_ROW_SUM: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (sts.x_last)
                begin
                    state_next = sts.row_last ? ST_DRAIN : ST_ROW_SQ;
                end
            end
            ST_DRAIN:   state_next = ST_BUMP_RD;
            ST_BUMP_RD:
            begin
                if (sts.bump_hit)
                begin
                    state_next = ST_BUMP_WR;
                end
                else if (sts.bump_end)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_BUMP_WR: state_next = sts.bump_end ? ST_FINISH : ST_BUMP_RD;
            ST_FINISH:  state_next = ST_RESULT;
            ST_GEN_RD:  state_next = ST_GEN_WAIT;
            ST_GEN_WAIT: state_next = ST_RESULT;
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_CLEAR;
        endcase
        // a dimension write restarts the clearing sweep
        if (sts.cfg_clear)
        begin
            state_next = ST_CLEAR;
        end
    end

    always_comb
    begin
        ctl = '0;
        unique case (state_reg)
            ST_CLEAR:    ctl.clear = 1'b1;
            ST_IDLE:     ctl.latch = s_tvalid;
            ST_DISPATCH: ctl = '0;
            ST_BOX:      ctl.box = 1'b1;
            ST_START:    ctl.start = !sts.box_empty;
            ST_ROW_SQ:   ctl.row_sq = 1'b1;
            ST_ROW_SUM:  ctl.row_sum = 1'b1;
            ST_SCAN:     ctl.scan = 1'b1;
            ST_DRAIN:    ctl.bump_start = 1'b1;
            ST_BUMP_RD:
            begin
                ctl.bump_rd  = 1'b1;
                ctl.bump_adv = !sts.bump_hit;
            end
            ST_BUMP_WR:
            begin
                ctl.bump_wr  = 1'b1;
                ctl.bump_adv = 1'b1;
            end
            ST_FINISH:   ctl.finish = 1'b1;
            ST_GEN_RD:   ctl.gen_rd = 1'b1;
            ST_GEN_WAIT: ctl.gen_cap = 1'b1;
            ST_RESULT:   ctl.load_out = out_free;
            default:     ctl = '0;
        endcase
    end

endmodule

/* rtl/vslp_datapath.sv */
module vslp_datapath #(
    parameter int MAX_DIM     = 128,
    parameter int BRICK       = 32,
    parameter int NUM_CLASSES = 9,
    parameter int MAX_LEVELS  = 3
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic [vslp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vslp_pkg::DIM_W-1:0]        cfg_data,
    input  logic [vslp_pkg::IN_DATA_W-1:0]    in_data,
    input  logic [vslp_pkg::CMD_W-1:0]        in_cmd,
    input  vslp_pkg::dp_cmd_t                 ctl,
    output vslp_pkg::dp_status_t              sts,
    output logic [vslp_pkg::OUT_DATA_W-1:0]   out_data
);
    import vslp_pkg::*;

    localparam int CW        = $clog2(MAX_DIM);
    localparam int VA_W      = 3 * CW;
    localparam int BW        = $clog2(BRICK);
    localparam int GRID_MAX  = (MAX_DIM + BRICK - 1) / BRICK;
    localparam int GW        = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
    localparam int GG_W      = GW + 1;
    localparam int TB_W      = 3 * GW;
    localparam int TB_N      = 1 << TB_W;
    localparam int LW        = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int NL_W      = $clog2(MAX_LEVELS + 1);
    localparam int GA_W      = LW + TB_W;
    localparam int CI_W      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int DIM_CLAMP = (MAX_DIM < 255) ? MAX_DIM : 255;
    localparam int DIM_RST   = (MAX_DIM < 128) ? MAX_DIM : 128;

    // configuration
    logic [DIM_W-1:0] dim_reg [3];
    logic [DIM_W-1:0] dim_wr;
    logic             cfg_clear;
    logic             vol_ok;

    // latched item
    cmd_code_t                cmd_reg;
    logic signed [COORD_W-1:0] c_reg [3];
    logic [COORD_W-1:0]       r_reg;
    logic [CLASS_W-1:0]       cls_reg;
    logic [LEVEL_W-1:0]       lvq_reg;
    logic [BRICK_W-1:0]       qb_reg [3];
    logic                     bad_class;

    // pyramid geometry
    logic [GG_W-1:0] grid [MAX_LEVELS][3];
    logic [NL_W-1:0] nlev;
    logic            nl_found;

    // scan box
    logic signed [D_W-1:0] lo_t [3];
    logic signed [D_W-1:0] hi_t [3];
    logic signed [D_W-1:0] lo_c [3];
    logic signed [D_W-1:0] hi_c [3];
    logic signed [D_W-1:0] dmax [3];
    logic                  empty_any;
    logic [CW-1:0]         lo_reg [3];
    logic [CW-1:0]         hi_reg [3];
    logic                  box_empty_reg;
    logic [SQ_W-1:0]       r2_reg;

    // scan counters and distance pipeline
    logic [CW-1:0]           x_reg;
    logic [CW-1:0]           y_reg;
    logic [CW-1:0]           z_reg;
    logic                    x_last;
    logic signed [D_W-1:0]   dx;
    logic signed [D_W-1:0]   dy;
    logic signed [D_W-1:0]   dz;
    logic signed [2*D_W-1:0] prod_x;
    logic signed [2*D_W-1:0] prod_y;
    logic signed [2*D_W-1:0] prod_z;
    logic [SQ_W-1:0]         sq_y_reg;
    logic [SQ_W-1:0]         sq_z_reg;
    logic [SUM_W-1:0]        dyz_reg;
    logic [VA_W-1:0]         vaddr;
    logic [TB_W-1:0]         vbrick;

    logic                    a_vld_reg;
    logic [SQ_W-1:0]         sq_x_reg;
    logic [VA_W-1:0]         a_addr_reg;
    logic [TB_W-1:0]         a_brick_reg;

    logic [CLASS_W-1:0]      vox_rdata;
    logic                    in_sphere;
    logic                    b_change;
    logic                    vox_we;
    logic [VA_W-1:0]         vox_waddr;
    logic [CLASS_W-1:0]      vox_wdata;

    // counters
    logic [CHANGED_W-1:0] changed_reg;
    logic [TB_N-1:0]      touched_reg;
    logic [CHANGED_W-1:0] cc_reg [NUM_CLASSES];
    logic [VALUE_W-1:0]   edit_reg;

    // generation pyramid
    logic [TB_W-1:0]   bi_reg;
    logic [LW-1:0]     bl_reg;
    logic [GW-1:0]     bsx;
    logic [GW-1:0]     bsy;
    logic [GW-1:0]     bsz;
    logic [GA_W-1:0]   bump_addr;
    logic              b_touched;
    logic              bump_hit;
    logic              last_lvl;
    logic [GA_W-1:0]   gen_addr_reg;
    logic [VALUE_W-1:0] gen_rdata;
    logic              gen_we;
    logic [GA_W-1:0]   gen_waddr;
    logic [VALUE_W-1:0] gen_wdata;
    logic [GA_W-1:0]   gen_raddr;

    // generation query
    logic              q_over;
    logic [4:0]        q_up;
    logic [LW-1:0]     q_lvl;
    logic [BRICK_W-1:0] qs [3];
    logic              q_ok;
    logic [GA_W-1:0]   q_addr;
    logic              q_ok_reg;
    logic [VALUE_W-1:0] gen_val_reg;

    // clearing sweep
    logic [VA_W-1:0] clr_cnt_reg;

    // result
    logic [CHANGED_W-1:0] out_changed_reg;
    logic [VALUE_W-1:0]   out_value_reg;
    logic                 out_status_reg;
    logic [VALUE_W-1:0]   res_value;

    // ---------------------------------------------------------------- config
    assign cfg_clear = cfg_valid && (cfg_index == REG_DIM_X || cfg_index == REG_DIM_Y ||
                                     cfg_index == REG_DIM_Z);
    assign dim_wr = (cfg_data > DIM_W'(DIM_CLAMP)) ? DIM_W'(DIM_CLAMP) : cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                dim_reg[a] <= DIM_W'(DIM_RST);
            end
        end
        else
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (cfg_clear && cfg_index == CFG_IDX_W'(a))
                begin
                    dim_reg[a] <= dim_wr;
                end
            end
        end
    end

    assign vol_ok = (dim_reg[0] != '0) && (dim_reg[1] != '0) && (dim_reg[2] != '0);

    // grid size per level: ceil(dim / (BRICK << level))
    always_comb
    begin
        for (int l = 0; l < MAX_LEVELS; l++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                grid[l][a] = GG_W'((int'(dim_reg[a]) + (BRICK << l) - 1) >> (BW + l));
            end
        end
    end

    always_comb
    begin
        nlev     = NL_W'(MAX_LEVELS);
        nl_found = 1'b0;
        for (int l = 0; l < MAX_LEVELS; l++)
        begin
            if (!nl_found && grid[l][0] == GG_W'(1) && grid[l][1] == GG_W'(1) &&
                grid[l][2] == GG_W'(1))
            begin
                nlev     = NL_W'(l + 1);
                nl_found = 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- item
    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            cmd_reg  <= cmd_code_t'(in_cmd);
            c_reg[0] <= $signed(in_data[15:0]);
            c_reg[1] <= $signed(in_data[31:16]);
            c_reg[2] <= $signed(in_data[47:32]);
            r_reg    <= in_data[63:48];
            cls_reg  <= in_data[67:64];
            lvq_reg  <= in_data[71:68];
            qb_reg[0] <= in_data[78:72];
            qb_reg[1] <= in_data[85:79];
            qb_reg[2] <= in_data[92:86];
        end
    end

    assign bad_class = {1'b0, cls_reg} >= 5'(NUM_CLASSES);

    // ---------------------------------------------------------------- box
    always_comb
    begin
        empty_any = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            // ceil((c - r) / 16) and floor((c + r) / 16)
            lo_t[a] = ($signed(D_W'(c_reg[a])) - $signed({2'b00, r_reg}) +
                       $signed(D_W'(15))) >>> 4;
            hi_t[a] = ($signed(D_W'(c_reg[a])) + $signed({2'b00, r_reg})) >>> 4;
            dmax[a] = $signed({10'd0, dim_reg[a]}) - $signed(D_W'(1));
            lo_c[a] = (lo_t[a] < $signed(D_W'(0))) ? $signed(D_W'(0)) : lo_t[a];
            hi_c[a] = (hi_t[a] > dmax[a]) ? dmax[a] : hi_t[a];
            if (lo_c[a] > hi_c[a])
            begin
                empty_any = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.box)
        begin
            for (int a = 0; a < 3; a++)
            begin
                lo_reg[a] <= lo_c[a][CW-1:0];
                hi_reg[a] <= hi_c[a][CW-1:0];
            end
            box_empty_reg <= empty_any;
            r2_reg        <= r_reg * r_reg;
        end
    end

    // ---------------------------------------------------------------- scan
    assign x_last = (x_reg == hi_reg[0]);
    assign vaddr  = {z_reg, y_reg, x_reg};
    assign vbrick = {GW'(z_reg >> BW), GW'(y_reg >> BW), GW'(x_reg >> BW)};

    assign dx = $signed(D_W'({x_reg, 4'b0000})) - $signed(D_W'(c_reg[0]));
    assign dy = $signed(D_W'({y_reg, 4'b0000})) - $signed(D_W'(c_reg[1]));
    assign dz = $signed(D_W'({z_reg, 4'b0000})) - $signed(D_W'(c_reg[2]));
    assign prod_x = dx * dx;
    assign prod_y = dy * dy;
    assign prod_z = dz * dz;

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            x_reg <= lo_reg[0];
            y_reg <= lo_reg[1];
            z_reg <= lo_reg[2];
        end
        else if (ctl.scan)
        begin
            if (x_last)
            begin
                x_reg <= lo_reg[0];
                if (y_reg == hi_reg[1])
                begin
                    y_reg <= lo_reg[1];
                    z_reg <= z_reg + 1'b1;
                end
                else
                begin
                    y_reg <= y_reg + 1'b1;
                end
            end
            else
            begin
                x_reg <= x_reg + 1'b1;
            end
        end
        if (ctl.row_sq)
        begin
            sq_y_reg <= prod_y[SQ_W-1:0];
            sq_z_reg <= prod_z[SQ_W-1:0];
        end
        if (ctl.row_sum)
        begin
            dyz_reg <= SUM_W'(sq_y_reg) + SUM_W'(sq_z_reg);
        end
        sq_x_reg    <= prod_x[SQ_W-1:0];
        a_addr_reg  <= vaddr;
        a_brick_reg <= vbrick;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= ctl.scan;
        end
    end

    // second stage: distance test and read-modify-write of the voxel
    assign in_sphere = (SUM_W'(sq_x_reg) + dyz_reg) <= SUM_W'(r2_reg);
    assign b_change  = a_vld_reg && in_sphere && (vox_rdata != cls_reg);

    assign vox_we    = ctl.clear || b_change;
    assign vox_waddr = ctl.clear ? clr_cnt_reg : a_addr_reg;
    assign vox_wdata = ctl.clear ? '0 : cls_reg;

    vslp_ram #(
        .WIDTH (CLASS_W),
        .DEPTH (1 << VA_W)
    ) u_voxel_ram (
        .clk   (clk),
        .we    (vox_we),
        .waddr (vox_waddr),
        .wdata (vox_wdata),
        .raddr (vaddr),
        .rdata (vox_rdata)
    );

    // ---------------------------------------------------------------- counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            changed_reg <= '0;
            touched_reg <= '0;
            edit_reg    <= '0;
            for (int k = 0; k < NUM_CLASSES; k++)
            begin
                cc_reg[k] <= '0;
            end
        end
        else
        begin
            if (ctl.latch)
            begin
                changed_reg <= '0;
            end
            else if (b_change)
            begin
                changed_reg <= changed_reg + 1'b1;
            end
            if (ctl.start)
            begin
                touched_reg <= '0;
            end
            else if (b_change)
            begin
                touched_reg[a_brick_reg] <= 1'b1;
            end
            if (cfg_clear)
            begin
                edit_reg <= '0;
                for (int k = 0; k < NUM_CLASSES; k++)
                begin
                    cc_reg[k] <= '0;
                end
            end
            else
            begin
                // old label leaves its count per voxel, new label gains the total at the end
                if (b_change && vox_rdata != '0 && {1'b0, vox_rdata} < 5'(NUM_CLASSES))
                begin
                    cc_reg[vox_rdata[CI_W-1:0]] <= cc_reg[vox_rdata[CI_W-1:0]] - 1'b1;
                end
                if (ctl.finish)
                begin
                    if (cls_reg != '0)
                    begin
                        cc_reg[cls_reg[CI_W-1:0]] <= cc_reg[cls_reg[CI_W-1:0]] + changed_reg;
                    end
                    if (changed_reg != '0)
                    begin
                        edit_reg <= edit_reg + 1'b1;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- pyramid
    assign b_touched = touched_reg[bi_reg];
    assign bsx = bi_reg[GW-1:0] >> bl_reg;
    assign bsy = bi_reg[2*GW-1:GW] >> bl_reg;
    assign bsz = bi_reg[3*GW-1:2*GW] >> bl_reg;
    assign bump_addr = {bl_reg, bsz, bsy, bsx};
    assign bump_hit  = b_touched && (GG_W'(bsx) < grid[bl_reg][0]) &&
                       (GG_W'(bsy) < grid[bl_reg][1]) && (GG_W'(bsz) < grid[bl_reg][2]);
    assign last_lvl  = (NL_W'(bl_reg) + NL_W'(1)) == nlev;

    always_ff @(posedge clk)
    begin
        if (ctl.bump_start)
        begin
            bi_reg <= '0;
            bl_reg <= '0;
        end
        else if (ctl.bump_adv)
        begin
            if (b_touched && !last_lvl)
            begin
                bl_reg <= bl_reg + 1'b1;
            end
            else
            begin
                bl_reg <= '0;
                bi_reg <= bi_reg + 1'b1;
            end
        end
        if (ctl.bump_rd)
        begin
            gen_addr_reg <= bump_addr;
        end
    end

    // query: levels above the top fold into the top level
    always_comb
    begin
        q_over = {1'b0, lvq_reg} >= 5'(nlev);
        q_up   = {1'b0, lvq_reg} - (5'(nlev) - 5'd1);
        q_lvl  = q_over ? LW'(nlev - NL_W'(1)) : LW'(lvq_reg);
        q_ok   = vol_ok;
        for (int a = 0; a < 3; a++)
        begin
            qs[a] = q_over ? (qb_reg[a] >> q_up) : qb_reg[a];
            if (QC_W'(qs[a]) >= QC_W'(grid[q_lvl][a]))
            begin
                q_ok = 1'b0;
            end
        end
    end

    assign q_addr = {q_lvl, GW'(qs[2]), GW'(qs[1]), GW'(qs[0])};

    always_ff @(posedge clk)
    begin
        if (ctl.gen_rd)
        begin
            q_ok_reg <= q_ok;
        end
        if (ctl.gen_cap)
        begin
            gen_val_reg <= q_ok_reg ? gen_rdata : '0;
        end
    end

    assign gen_we    = (ctl.clear && clr_cnt_reg[VA_W-1:GA_W] == '0) || ctl.bump_wr;
    assign gen_waddr = ctl.clear ? clr_cnt_reg[GA_W-1:0] : gen_addr_reg;
    assign gen_wdata = ctl.clear ? '0 : gen_rdata + 1'b1;
    assign gen_raddr = ctl.gen_rd ? q_addr : bump_addr;

    vslp_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (1 << GA_W)
    ) u_gen_ram (
        .clk   (clk),
        .we    (gen_we),
        .waddr (gen_waddr),
        .wdata (gen_wdata),
        .raddr (gen_raddr),
        .rdata (gen_rdata)
    );

    // ---------------------------------------------------------------- clear sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cfg_clear)
        begin
            clr_cnt_reg <= '0;
        end
        else if (ctl.clear)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // ---------------------------------------------------------------- result
    always_comb
    begin
        unique case (cmd_reg)
            CMD_PAINT: res_value = '0;
            CMD_GEN:   res_value = gen_val_reg;
            CMD_COUNT: res_value = bad_class ? '0 : VALUE_W'(cc_reg[cls_reg[CI_W-1:0]]);
            CMD_EDIT:  res_value = edit_reg;
            default:   res_value = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            out_changed_reg <= changed_reg;
            out_value_reg   <= res_value;
            out_status_reg  <= (cmd_reg == CMD_PAINT || cmd_reg == CMD_COUNT) && bad_class;
        end
    end

    assign out_data = {1'b0, out_status_reg, out_value_reg, out_changed_reg};

    // ---------------------------------------------------------------- status
    assign sts.code      = cmd_reg;
    assign sts.bad_class = bad_class;
    assign sts.vol_ok    = vol_ok;
    assign sts.box_empty = box_empty_reg;
    assign sts.x_last    = x_last;
    assign sts.row_last  = (y_reg == hi_reg[1]) && (z_reg == hi_reg[2]);
    assign sts.bump_hit  = bump_hit;
    assign sts.bump_end  = (&bi_reg) && (!b_touched || last_lvl);
    assign sts.clr_last  = &clr_cnt_reg;
    assign sts.cfg_clear = cfg_clear;

endmodule

/* rtl/voxel_sphere_label_painter_top.sv */
// voxel sphere label painter
// s_* beat: one command (tuser) with sphere, class and brick query fields (tdata).
// m_* beat: one result per command, held in an output register, so the next
// command is taken while a result still waits on m_tready.
// cfg_* beat: writes dim_x/dim_y/dim_z (index 0..2); any such write clears the
// volume, the generation pyramid, the class counts and the edit counter.
// reset and every dimension write start a clearing sweep over all (2**clog2(MAX_DIM))**3
// voxel memory addresses (2097152 by default); no command is taken until it ends.
// a class count or edit count query goes straight to its result; a generation read first
// reads the pyramid memory and then captures the value. a paint computes the clipped
// box, then scans it one voxel per cycle within a row (voxel memory read-modify-write),
// with a row distance step before each box row, then walks the level-0 brick slots and
// updates the generation counter of each touched brick on each level.
// a stalled receiver only holds the output register; the block then finishes the
// next command and waits with it until the register frees.
module voxel_sphere_label_painter_top #(
    parameter int MAX_DIM     = 128,
    parameter int BRICK       = 32,
    parameter int NUM_CLASSES = 9,
    parameter int MAX_LEVELS  = 3
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // center_x, center_y, center_z, radius, class_id, level, brick_x, brick_y, brick_z
    input  logic [vslp_pkg::IN_DATA_W-1:0]   s_tdata,
    // command
    input  logic [vslp_pkg::CMD_W-1:0]       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // changed_count, read_value, status
    output logic [vslp_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [vslp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vslp_pkg::DIM_W-1:0]       cfg_data
);
    import vslp_pkg::*;

    dp_cmd_t    ctl;
    dp_status_t sts;

    assign cfg_ready = 1'b1;

    vslp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    vslp_datapath #(
        .MAX_DIM     (MAX_DIM),
        .BRICK       (BRICK),
        .NUM_CLASSES (NUM_CLASSES),
        .MAX_LEVELS  (MAX_LEVELS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata),
        .in_cmd    (s_tuser),
        .ctl       (ctl),
        .sts       (sts),
        .out_data  (m_tdata)
    );

endmodule
